>>> hw/rtl/string_literal_unescaper_top_defines.svh
// ----------------------------------------------------------------------------
// String literal unescaper assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef STRING_LITERAL_UNESCAPER_TOP_DEFINES_SVH
`define STRING_LITERAL_UNESCAPER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define SLU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define SLU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/slu_pkg.sv
// ----------------------------------------------------------------------------
// String literal unescaper package
// Word types, character codes, phase encoding and decode helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package slu_pkg;

	localparam int MAX_LEN   = 1024;
	localparam int DEC_W     = 11;
	localparam int CONS_W    = 12;
	localparam int RUN_DEPTH = 4;
	localparam int RUN_CNT_W = 3;
	localparam int PADDR_W   = 3;

	// register index (paddr[2])
	localparam logic REG_DELIM_IDX = 1'b0;

	// result kinds
	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_FINISH = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	typedef enum logic [6:0] {
		PH_FIRST = 7'b0000001,
		PH_BODY  = 7'b0000010,
		PH_ESC   = 7'b0000100,
		PH_HEX1  = 7'b0001000,
		PH_HEX2  = 7'b0010000,
		PH_HEX3  = 7'b0100000,
		PH_DONE  = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       start_of_literal;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic [7:0]        out_byte;
		logic [DEC_W-1:0]  final_length;
		logic [CONS_W-1:0] chars_consumed;
		logic              last_of_run;
	} out_word_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] val;
	} esc_t;

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c inside {["0":"9"]}) begin
			h.val = 4'(c - "0");
		end else if (c inside {["a":"f"]}) begin
			h.val = 4'(c - "a" + 8'd10);
		end else if (c inside {["A":"F"]}) begin
			h.val = 4'(c - "A" + 8'd10);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	// single-character escapes after '$'
	function automatic esc_t esc_map(input logic [7:0] c);
		esc_t e;
		e.ok  = 1'b1;
		e.val = c;
		case (c)
			CH_SQUOTE, CH_DQUOTE, CH_DOLLAR: e.val = c;
			"N", "n", "L", "l":              e.val = CH_LF;
			"P", "p":                        e.val = CH_FF;
			"R", "r":                        e.val = CH_CR;
			"T", "t":                        e.val = CH_TAB;
			default:                         e.ok  = 1'b0;
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/string_literal_unescaper_top.sv
// Flow: an accepted word waits in the input register until the result queue is
//   free, then its decoded run is loaded there and the head drives the outputs.
// Throughput: one input word per cycle while each word gives at most one
//   result and results are taken; a longer run holds the input until it drains.
// Reset: arst_n clears phase, counters and queue at once; delimiter -> '\''.
// ----------------------------------------------------------------------------
// String literal unescaper, top level
// Decodes a quoted literal one character per word into bytes, with UTF-8
// output of wide hex escapes, a finish word and an error word.
// ----------------------------------------------------------------------------
`default_nettype none

`include "string_literal_unescaper_top_defines.svh"

module string_literal_unescaper_top
	import slu_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// character words
	input  wire logic               char_valid,
	output      logic               char_ready,
	input  wire in_word_t           char_word,
	// result words
	output      logic               res_valid,
	input  wire logic               res_ready,
	output      out_word_t          res_word,
	// APB-style configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output      logic [31:0]        prdata,
	output      logic               pready
);

	// ------------------------------------------------------------------
	// Configuration: one register, the delimiter. Double quote = wide mode.
	// ------------------------------------------------------------------
	logic [7:0] delim_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DELIM_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= CH_SQUOTE;
		end else if (cfg_wr) begin
			delim_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == REG_DELIM_IDX) ? {24'd0, delim_q} : 32'd0;

	// ------------------------------------------------------------------
	// Input register. Drains whenever the result queue can take the
	// decoded run, so a new word can enter in the same cycle.
	// ------------------------------------------------------------------
	logic      valid_s1;
	in_word_t  word_s1;
	logic      run_free;
	logic      load;
	logic      char_take;
	logic      res_take;

	logic [RUN_CNT_W-1:0] run_cnt_q;
	out_word_t            run_q [RUN_DEPTH];

	assign res_take  = res_valid && res_ready;
	// queue empty, or its last word leaves this cycle
	assign run_free  = (run_cnt_q == '0) || ((run_cnt_q == RUN_CNT_W'(1)) && res_take);
	assign load      = valid_s1 && run_free;
	assign char_ready = !valid_s1 || load;
	assign char_take = char_valid && char_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_take) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_take) begin
			word_s1 <= char_word;
		end
	end

	// ------------------------------------------------------------------
	// Parser state
	// ------------------------------------------------------------------
	phase_t            phase_q;
	logic [DEC_W-1:0]  dec_q;
	logic [CONS_W-1:0] cons_q;
	logic [15:0]       acc_q;

	// ------------------------------------------------------------------
	// Decode: state + one character -> next state and up to four results
	// (three UTF-8 bytes plus a finish word at most).
	// ------------------------------------------------------------------
	phase_t               ph;
	logic [DEC_W-1:0]     dec;
	logic [CONS_W-1:0]    cons;
	logic [15:0]          acc;
	logic [7:0]           c;
	logic                 wide;
	logic                 do_body;
	logic                 emit;
	logic [15:0]          ev;
	logic                 fin;
	logic                 err;
	logic [1:0]           nb;
	logic [7:0]           bytes [3];
	hex_t                 hv;
	esc_t                 ev_map;
	logic [RUN_CNT_W-1:0] n_new;
	out_word_t            new_run [RUN_DEPTH];

	always_comb begin
		ph      = phase_q;
		dec     = dec_q;
		cons    = cons_q;
		acc     = acc_q;
		c       = word_s1.char_in;
		wide    = (delim_q == CH_DQUOTE);
		do_body = 1'b0;
		emit    = 1'b0;
		ev      = 16'd0;
		fin     = 1'b0;
		err     = 1'b0;
		nb      = 2'd0;
		for (int i = 0; i < 3; i++) begin
			bytes[i] = 8'd0;
		end
		hv      = hex_digit(c);
		ev_map  = esc_map(c);

		// start marker restarts the literal
		if (word_s1.start_of_literal) begin
			ph   = PH_FIRST;
			dec  = '0;
			cons = '0;
			acc  = '0;
		end

		case (ph)
			PH_FIRST: begin
				if (c != CH_NUL && c == delim_q) begin
					cons = cons + CONS_W'(1);
					ph   = PH_BODY;
				end else begin
					ph      = PH_BODY;
					do_body = 1'b1;
				end
			end
			PH_BODY: begin
				do_body = 1'b1;
			end
			PH_ESC: begin
				if (c == CH_NUL) begin
					fin = 1'b1;           // '$' then NUL ends the literal
				end else if (ev_map.ok) begin
					cons = cons + CONS_W'(1);
					emit = 1'b1;
					ev   = {8'd0, ev_map.val};
				end else if (hv.ok) begin
					cons = cons + CONS_W'(1);
					acc  = {12'd0, hv.val};
					ph   = PH_HEX1;
				end else begin
					err = 1'b1;
				end
			end
			PH_HEX1, PH_HEX2, PH_HEX3: begin
				if (!hv.ok) begin
					err = 1'b1;
				end else begin
					cons = cons + CONS_W'(1);
					acc  = {acc[11:0], hv.val};
					ev   = acc;
					if (ph == PH_HEX1 && !wide) begin
						emit = 1'b1;
					end else if (ph == PH_HEX1) begin
						ph = PH_HEX2;
					end else if (ph == PH_HEX2) begin
						ph = PH_HEX3;
					end else begin
						emit = 1'b1;
					end
				end
			end
			default: ;                    // done: ignore until next start
		endcase

		// plain body character; '$' test precedes the delimiter test
		if (do_body) begin
			if (c == CH_NUL) begin
				fin = 1'b1;
			end else if (c == CH_DOLLAR) begin
				cons = cons + CONS_W'(1);
				ph   = PH_ESC;
			end else if (c == delim_q) begin
				cons = cons + CONS_W'(1);
				fin  = 1'b1;
			end else begin
				cons     = cons + CONS_W'(1);
				nb       = 2'd1;
				bytes[0] = c;
				dec      = dec + DEC_W'(1);
				fin      = (dec >= DEC_W'(MAX_LEN));
			end
		end

		// decoded value: one byte narrow, UTF-8 wide
		if (emit) begin
			if (!wide || ev < 16'h0080) begin
				nb       = 2'd1;
				bytes[0] = ev[7:0];
			end else if (ev < 16'h0800) begin
				nb       = 2'd2;
				bytes[0] = {3'b110, ev[10:6]};
				bytes[1] = {2'b10, ev[5:0]};
			end else begin
				nb       = 2'd3;
				bytes[0] = {4'b1110, ev[15:12]};
				bytes[1] = {2'b10, ev[11:6]};
				bytes[2] = {2'b10, ev[5:0]};
			end
			dec = dec + DEC_W'(nb);
			ph  = PH_BODY;
			fin = (dec >= DEC_W'(MAX_LEN));  // overshoot also finishes
		end

		if (fin || err) begin
			ph = PH_DONE;
		end

		// assemble the run: bytes first, then finish or error
		n_new = RUN_CNT_W'(nb) + RUN_CNT_W'(fin || err);
		for (int i = 0; i < RUN_DEPTH; i++) begin
			new_run[i] = '0;
			if (i < 3) begin
				new_run[i].out_byte = (2'(i) < nb) ? bytes[i] : 8'd0;
			end
			if (2'(i) == nb && fin) begin
				new_run[i].result_kind    = KIND_FINISH;
				new_run[i].final_length   = dec;
				new_run[i].chars_consumed = cons;
			end else if (2'(i) == nb && err) begin
				new_run[i].result_kind = KIND_ERROR;
			end
			new_run[i].last_of_run = (n_new != '0) && (RUN_CNT_W'(i) == n_new - RUN_CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			dec_q   <= '0;
			cons_q  <= '0;
			acc_q   <= '0;
		end else if (load) begin
			phase_q <= ph;
			dec_q   <= dec;
			cons_q  <= cons;
			acc_q   <= acc;
		end
	end

	// ------------------------------------------------------------------
	// Result queue: a short shift line, head word drives the outputs.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cnt_q <= '0;
		end else if (load) begin
			run_cnt_q <= n_new;
		end else if (res_take) begin
			run_cnt_q <= run_cnt_q - RUN_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < RUN_DEPTH; i++) begin
				run_q[i] <= new_run[i];
			end
		end else if (res_take) begin
			for (int i = 0; i < RUN_DEPTH - 1; i++) begin
				run_q[i] <= run_q[i+1];
			end
		end
	end

	assign res_valid = (run_cnt_q != '0);
	assign res_word  = run_q[0];

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`SLU_ASSERT_IMPL(a_last_flag, res_valid, res_word.last_of_run == (run_cnt_q == RUN_CNT_W'(1)), "last_of_run out of step with queue count")
	`SLU_ASSERT_IMPL(a_hold_input, valid_s1 && run_cnt_q > RUN_CNT_W'(1), !char_ready, "input taken while queue still busy")
	`SLU_ASSERT_NEXT(a_run_loaded, load && n_new != '0, res_valid && run_cnt_q == $past(n_new), "decoded run not loaded into queue")
	`SLU_ASSERT_IMPL(a_done_quiet, load && phase_q == PH_DONE && !word_s1.start_of_literal, n_new == '0, "result after literal finished")

endmodule

`default_nettype wire

>>> test/slu_decode_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String literal unescaper decode checker
// Watches the character, result and configuration channels, predicts the
// result words of each accepted character word and compares them in order.
// ----------------------------------------------------------------------------
module slu_decode_check
	import slu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	input  logic               char_ready,
	input  in_word_t           char_word,
	input  logic               res_valid,
	input  logic               res_ready,
	input  out_word_t          res_word,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output int                 mismatch_count,
	output int                 pending_results
);

	// decoder image
	phase_t      phase;
	int unsigned dec_count;
	int unsigned cons_count;
	logic [15:0] code_acc;
	logic [7:0]  delim;

	out_word_t   expected_words[$];

	function automatic int hex_nibble(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	function automatic void add_result(logic [1:0] kind, logic [7:0] b, int unsigned len,
			int unsigned cons);
		out_word_t w;
		w.result_kind    = kind;
		w.out_byte       = b;
		w.final_length   = len[DEC_W-1:0];
		w.chars_consumed = cons[CONS_W-1:0];
		w.last_of_run    = 1'b0;
		expected_words.push_back(w);
	endfunction

	function automatic void finish_literal();
		add_result(KIND_FINISH, 8'h00, dec_count, cons_count);
		phase = PH_DONE;
	endfunction

	function automatic void abandon_literal();
		add_result(KIND_ERROR, 8'h00, 0, 0);
		phase = PH_DONE;
	endfunction

	// one decoded code point; wide mode goes out as UTF-8
	function automatic void emit_code(logic [15:0] v);
		if (delim != CH_DQUOTE || v < 16'h0080) begin
			add_result(KIND_BYTE, v[7:0], 0, 0);
			dec_count += 1;
		end else if (v < 16'h0800) begin
			add_result(KIND_BYTE, 8'hC0 | {3'b000, v[10:6]}, 0, 0);
			add_result(KIND_BYTE, 8'h80 | {2'b00, v[5:0]}, 0, 0);
			dec_count += 2;
		end else begin
			add_result(KIND_BYTE, 8'hE0 | {4'h0, v[15:12]}, 0, 0);
			add_result(KIND_BYTE, 8'h80 | {2'b00, v[11:6]}, 0, 0);
			add_result(KIND_BYTE, 8'h80 | {2'b00, v[5:0]}, 0, 0);
			dec_count += 3;
		end
		phase = PH_BODY;
		if (dec_count >= MAX_LEN) finish_literal();
	endfunction

	function automatic void take_body(logic [7:0] c);
		if (c == CH_NUL) begin
			finish_literal();
		end else if (c == CH_DOLLAR) begin
			cons_count++;
			phase = PH_ESC;
		end else if (c == delim) begin
			cons_count++;
			finish_literal();
		end else begin
			cons_count++;
			add_result(KIND_BYTE, c, 0, 0);
			dec_count++;
			if (dec_count >= MAX_LEN) finish_literal();
		end
	endfunction

	function automatic void take_escape(logic [7:0] c);
		int h;
		if (c == CH_NUL) begin
			finish_literal();
			return;
		end
		case (c)
			CH_SQUOTE, CH_DQUOTE, CH_DOLLAR: begin
				cons_count++;
				emit_code({8'h00, c});
			end
			"N", "n", "L", "l": begin
				cons_count++;
				emit_code({8'h00, CH_LF});
			end
			"P", "p": begin
				cons_count++;
				emit_code({8'h00, CH_FF});
			end
			"R", "r": begin
				cons_count++;
				emit_code({8'h00, CH_CR});
			end
			"T", "t": begin
				cons_count++;
				emit_code({8'h00, CH_TAB});
			end
			default: begin
				h = hex_nibble(c);
				if (h < 0) begin
					abandon_literal();
				end else begin
					cons_count++;
					code_acc = 16'(h);
					phase = PH_HEX1;
				end
			end
		endcase
	endfunction

	function automatic void take_hex(logic [7:0] c);
		int h;
		h = hex_nibble(c);
		if (h < 0) begin
			abandon_literal();
			return;
		end
		cons_count++;
		code_acc = {code_acc[11:0], 4'(h)};
		if (phase == PH_HEX1 && delim != CH_DQUOTE) emit_code(code_acc);
		else if (phase == PH_HEX1) phase = PH_HEX2;
		else if (phase == PH_HEX2) phase = PH_HEX3;
		else emit_code(code_acc);
	endfunction

	function automatic void predict_word(in_word_t w);
		int        base_size;
		out_word_t tail;
		base_size = expected_words.size();
		if (w.start_of_literal) begin
			phase      = PH_FIRST;
			dec_count  = 0;
			cons_count = 0;
			code_acc   = '0;
		end
		case (phase)
			PH_FIRST: begin
				phase = PH_BODY;
				if (w.char_in != CH_NUL && w.char_in == delim) cons_count++;
				else take_body(w.char_in);
			end
			PH_BODY:                   take_body(w.char_in);
			PH_ESC:                    take_escape(w.char_in);
			PH_HEX1, PH_HEX2, PH_HEX3: take_hex(w.char_in);
			default: ;
		endcase
		if (expected_words.size() > base_size) begin
			tail = expected_words.pop_back();
			tail.last_of_run = 1'b1;
			expected_words.push_back(tail);
		end
	endfunction

	function automatic void check_result(out_word_t got);
		out_word_t want;
		bit        bad;
		if (expected_words.size() == 0) begin
			$display("%0t: unexpected result word, expected none, got kind %0d byte %02h",
				$time, got.result_kind, got.out_byte);
			mismatch_count++;
			return;
		end
		want = expected_words.pop_front();
		bad  = 1'b0;
		if (got.result_kind !== want.result_kind) begin
			bad = 1'b1;
			$display("%0t: result_kind expected %0d got %0d", $time,
				want.result_kind, got.result_kind);
		end
		if (got.out_byte !== want.out_byte) begin
			bad = 1'b1;
			$display("%0t: out_byte expected %02h got %02h", $time,
				want.out_byte, got.out_byte);
		end
		if (got.final_length !== want.final_length) begin
			bad = 1'b1;
			$display("%0t: final_length expected %0d got %0d", $time,
				want.final_length, got.final_length);
		end
		if (got.chars_consumed !== want.chars_consumed) begin
			bad = 1'b1;
			$display("%0t: chars_consumed expected %0d got %0d", $time,
				want.chars_consumed, got.chars_consumed);
		end
		if (got.last_of_run !== want.last_of_run) begin
			bad = 1'b1;
			$display("%0t: last_of_run expected %0d got %0d", $time,
				want.last_of_run, got.last_of_run);
		end
		if (bad) mismatch_count++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase          = PH_FIRST;
			dec_count      = 0;
			cons_count     = 0;
			code_acc       = '0;
			delim          = CH_SQUOTE;
			mismatch_count = 0;
			expected_words.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_DELIM_IDX)
				delim = pwdata[7:0];
			if (res_valid && res_ready) check_result(res_word);
			if (char_valid && char_ready) predict_word(char_word);
		end
		pending_results = expected_words.size();
	end

endmodule

>>> test/string_literal_unescaper_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String literal unescaper testbench
// Feeds directed and random literals under several delimiters, with random
// idle cycles on both sides and one long result hold-off; the decode checker
// predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
module string_literal_unescaper_top_tb;
	import slu_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving
	localparam int HOLD_CYCLES    = 300;   // long result hold-off
	localparam int DRAIN_CYCLES   = 4;     // covers words that give no result
	localparam logic [PADDR_W-1:0] DELIM_ADDR = {REG_DELIM_IDX, 2'b00};

	// $ followed by one of these is a single-character escape
	localparam logic [7:0] SIMPLE_ESC [13] = '{CH_SQUOTE, CH_DQUOTE, CH_DOLLAR,
		"N", "n", "L", "l", "P", "p", "R", "r", "T", "t"};
	// characters that are neither hex digits nor simple escapes
	localparam logic [7:0] BAD_ESC [8] = '{"!", "#", "%", "@", "X", "y", "z", "g"};

	logic               clk;
	logic               arst_n;
	logic               char_valid;
	logic               char_ready;
	in_word_t           char_word;
	logic               res_valid;
	logic               res_ready;
	out_word_t          res_word;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int                 mismatch_count;
	int                 pending_results;

	// stimulus control, written at falling edges; the stall counter at rising edges
	logic               idle_on;
	int                 hold_req;
	logic [7:0]         delim_now;
	int                 sent_count;
	int                 stall_cycles;

	string_literal_unescaper_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_word (char_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	slu_decode_check u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_valid     (char_valid),
		.char_ready     (char_ready),
		.char_word      (char_word),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res_word       (res_word),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatch_count (mismatch_count),
		.pending_results(pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Word sender. Inputs change on the falling edge; acceptance is seen
	// at the rising edge. A gap drops valid for a whole cycle, so valid
	// never falls and rises in the same step.
	// ------------------------------------------------------------------
	task automatic offer_char(logic [7:0] c, logic first);
		in_word_t w;
		w.char_in          = c;
		w.start_of_literal = first;
		if (idle_on && $urandom_range(99) < 17) begin
			char_valid <= 1'b0;
			@(negedge clk);
		end
		char_valid <= 1'b1;
		char_word  <= w;
		@(posedge clk);
		while (!char_ready) @(posedge clk);
		@(negedge clk);
		sent_count++;
	endtask

	task automatic offer_text(string s, bit first);
		for (int i = 0; i < s.len(); i++) offer_char(s[i], first && i == 0);
	endtask

	// Drop valid and wait until every predicted word is out, plus DRAIN_CYCLES
	// for a trailing word that gives no result.
	task automatic wait_idle();
		char_valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Setup cycle then access cycle; the register takes the value at the
	// rising edge with psel, penable, pwrite and pready all high.
	task automatic write_delimiter(logic [7:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= DELIM_ADDR;
		pwdata  <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		delim_now  = value;
	endtask

	function automatic logic [7:0] hex_char_of(logic [3:0] nib);
		if (nib < 4'd10) return "0" + {4'h0, nib};
		return ($urandom_range(1) ? "a" : "A") + {4'h0, nib} - 8'd10;
	endfunction

	// ordinary body character: not NUL, not '$', not the delimiter
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		c = 8'($urandom_range(1, 255));
		if (c == CH_DOLLAR || c == delim_now) c = "k";
		return c;
	endfunction

	// '$' then a simple escape, a hex escape of the width the mode wants
	// (now and then broken by a non-hex digit), or a malformed escape
	task automatic send_escape();
		int          pick;
		int          digits;
		logic [15:0] v;
		logic [7:0]  c;
		pick = $urandom_range(99);
		offer_char(CH_DOLLAR, 1'b0);
		if (pick < 40) begin
			offer_char(SIMPLE_ESC[$urandom_range(12)], 1'b0);
		end else if (pick < 92) begin
			if (delim_now == CH_DQUOTE) begin
				digits = 4;
				// spread over the 1, 2 and 3 byte UTF-8 ranges
				case ($urandom_range(2))
					0:       v = 16'($urandom_range(16'h0000, 16'h007F));
					1:       v = 16'($urandom_range(16'h0080, 16'h07FF));
					default: v = 16'($urandom_range(16'h0800, 16'hFFFF));
				endcase
			end else begin
				digits = 2;
				v      = 16'($urandom_range(255));
			end
			for (int i = digits - 1; i >= 0; i--) begin
				c = hex_char_of(v[4*i +: 4]);
				if ($urandom_range(99) < 3) c = BAD_ESC[$urandom_range(7)];
				offer_char(c, 1'b0);
			end
		end else begin
			c = $urandom_range(1) ? 8'($urandom_range(8'h80, 8'hFF))
			                      : BAD_ESC[$urandom_range(7)];
			offer_char(c, 1'b0);
		end
	endtask

	// literal with random content, malformed escapes included, and a random ending
	task automatic send_literal();
		int body_len;
		int pick;
		body_len = $urandom_range(0, 10);
		if (delim_now != CH_NUL && $urandom_range(99) < 80) offer_char(delim_now, 1'b1);
		else offer_char(plain_char(), 1'b1);
		repeat (body_len) begin
			pick = $urandom_range(99);
			if (pick < 65) offer_char(plain_char(), 1'b0);
			else if (pick < 92) send_escape();
			else offer_char(8'($urandom_range(255)), 1'b0);
		end
		pick = $urandom_range(99);
		if (pick < 70) offer_char(delim_now, 1'b0);
		else if (pick < 90) offer_char(CH_NUL, 1'b0);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6))
			offer_char(8'($urandom_range(255)), $urandom_range(99) < 30);
	endtask

	task automatic run_random(int budget);
		int stop_at;
		stop_at = sent_count + budget;
		while (sent_count < stop_at) begin
			if ($urandom_range(99) < 85) send_literal();
			else send_noise();
		end
	endtask

	// ------------------------------------------------------------------
	// Result receiver: random stalls, plus one long hold-off on request
	// so the block fills and stops taking characters.
	// ------------------------------------------------------------------
	initial begin
		int hold_seen;
		hold_seen = 0;
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen  = hold_req;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			res_ready <= !(idle_on && $urandom_range(99) < 17);
		end
	end

	// watchdog: counts cycles in which no word moves on either channel
	always @(posedge clk) begin
		if (!arst_n || (char_valid && char_ready) || (res_valid && res_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n     = 1'b0;
		char_valid = 1'b0;
		char_word  = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		idle_on    = 1'b1;
		hold_req   = 0;
		delim_now  = CH_SQUOTE;
		sent_count = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// narrow mode, reset delimiter: skipped leading quote, plain byte,
		// $N, two-digit hex, $$, 0xFF byte, closing quote, a word after the
		// finish, non-hex digit inside a hex escape, bad escape, NUL right
		// after '$', empty literal, first character not a delimiter
		offer_text("'a$N$41$$", 1'b1);
		offer_char(8'hFF, 1'b0);
		offer_text("'x", 1'b0);
		offer_text("$0g", 1'b1);
		offer_text("$q", 1'b1);
		offer_text("$", 1'b1);
		offer_char(CH_NUL, 1'b0);
		offer_char(CH_NUL, 1'b1);
		offer_text("z$t'", 1'b1);
		wait_idle();

		// wide mode: surrogate value as plain 3 bytes, 2-byte and 1-byte
		// UTF-8, then a 3-byte run in a fresh literal
		write_delimiter(CH_DQUOTE);
		offer_text("\"$D800$00e9$t$7A\"", 1'b1);
		offer_text("\"$20AC\"", 1'b1);
		hold_req <= hold_req + 1;
		run_random(25);
		wait_idle();

		// '$' as delimiter: leading '$' is skipped, later ones escape,
		// and the literal can only end on NUL
		write_delimiter(CH_DOLLAR);
		offer_text("$a$$b$", 1'b1);
		offer_char(CH_NUL, 1'b0);
		run_random(20);
		wait_idle();

		// register extremes
		write_delimiter(8'h00);
		run_random(15);
		wait_idle();
		write_delimiter(8'hFF);
		run_random(15);
		wait_idle();

		// back to the reset value, with a stretch of no idling
		write_delimiter(CH_SQUOTE);
		idle_on <= 1'b0;
		run_random(30);
		idle_on <= 1'b1;
		run_random(20);

		wait_idle();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
